// ===== src/asis_pkg.sv =====
// Shared types and character constants for the ASCII signed integer scanner.
`timescale 1ns / 1ps

package asis_pkg;

   // Line scanner phase codes
   localparam logic [1:0] PH_IDLE   = 2'd0;  // between tokens
   localparam logic [1:0] PH_SIGN   = 2'd1;  // sign seen, no digit yet
   localparam logic [1:0] PH_DIGITS = 2'd2;  // inside a number
   localparam logic [1:0] PH_STOP   = 2'd3;  // rest of line ignored

   // Stop reason codes
   localparam logic [1:0] RSN_NONE    = 2'd0;
   localparam logic [1:0] RSN_BADCHAR = 2'd1;
   localparam logic [1:0] RSN_OVFL    = 2'd2;
   localparam logic [1:0] RSN_NODIGIT = 2'd3;

   // Character codes
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;  // tab; LF, VT, FF, CR follow it
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [2:0] MAX_FIELDS_RESET = 3'd7;

   // Magnitude limits, widened for the accumulate result
   localparam int unsigned ACC_W = 36;
   localparam logic [ACC_W-1:0] POS_LIMIT = 36'h0_7fff_ffff;
   localparam logic [ACC_W-1:0] NEG_LIMIT = 36'h0_8000_0000;

   // Line state carried between characters
   typedef struct packed {
      logic [1:0]  phase;
      logic        negative;
      logic [31:0] acc;
      logic [2:0]  count;
      logic [1:0]  reason;
   } line_state_type;

   // One result item
   typedef struct packed {
      logic        emit;        // a result item is produced
      logic [31:0] value;
      logic        value_valid;
      logic        line_end;
      logic [2:0]  field_count;
      logic [1:0]  stop_reason;
   } result_type;

   localparam line_state_type LINE_CLEAR = '{
      phase: PH_IDLE, negative: 1'b0, acc: 32'd0, count: 3'd0, reason: RSN_NONE};

endpackage

// ===== src/asis_step.sv =====
// Combinational next-state and result logic for one character.
`timescale 1ns / 1ps

module asis_step (
   input  asis_pkg::line_state_type cur,
   input  logic [7:0]               ch,
   input  logic                     eol,
   input  logic [2:0]               max_fields,
   output asis_pkg::line_state_type nxt,
   output asis_pkg::result_type     res
);

   logic                    is_digit;
   logic                    is_blank;
   logic                    is_sign;
   logic [31:0]             digit;
   logic [asis_pkg::ACC_W-1:0] acc_x10;
   logic [asis_pkg::ACC_W-1:0] limit;
   asis_pkg::line_state_type st;
   logic                    emit;
   logic [31:0]             val;

   // Character classes
   assign is_digit = (ch >= asis_pkg::CH_ZERO) && (ch <= asis_pkg::CH_NINE);
   assign is_blank = (ch == asis_pkg::CH_SPACE) ||
                     ((ch >= asis_pkg::CH_TAB) && (ch <= asis_pkg::CH_CR));
   assign is_sign  = (ch == asis_pkg::CH_PLUS) || (ch == asis_pkg::CH_MINUS);
   assign digit    = {28'd0, ch[3:0]};

   // acc * 10 + digit as shift-add
   assign acc_x10 = {1'b0, cur.acc, 3'b000} + {3'b000, cur.acc, 1'b0}
                    + {{(asis_pkg::ACC_W-4){1'b0}}, ch[3:0]};
   assign limit   = cur.negative ? asis_pkg::NEG_LIMIT : asis_pkg::POS_LIMIT;

   always_comb begin
      st   = cur;
      emit = 1'b0;
      val  = 32'd0;

      // Character step; NUL is ignored
      if (ch != asis_pkg::CH_NUL) begin
         unique case (cur.phase)
            asis_pkg::PH_DIGITS: begin
               if (is_digit) begin
                  if (acc_x10 > limit) begin
                     st.reason = asis_pkg::RSN_OVFL;
                     st.phase  = asis_pkg::PH_STOP;
                  end else begin
                     st.acc = acc_x10[31:0];
                  end
               end else begin
                  emit     = 1'b1;
                  val      = cur.negative ? (32'd0 - cur.acc) : cur.acc;
                  st.count = cur.count + 3'd1;
                  st.phase = asis_pkg::PH_IDLE;
               end
            end
            asis_pkg::PH_SIGN: begin
               if (is_digit) begin
                  st.acc   = digit;
                  st.phase = asis_pkg::PH_DIGITS;
               end else begin
                  st.reason = asis_pkg::RSN_NODIGIT;
                  st.phase  = asis_pkg::PH_STOP;
               end
            end
            asis_pkg::PH_IDLE,
            asis_pkg::PH_STOP: begin
            end
            default: begin
            end
         endcase

         // Token start, from idle or right after a number ends
         if (cur.phase == asis_pkg::PH_IDLE || emit) begin
            if (st.count >= max_fields) begin
               st.phase = asis_pkg::PH_STOP;
            end else if (is_blank) begin
               st.phase = asis_pkg::PH_IDLE;
            end else if (is_sign) begin
               st.negative = (ch == asis_pkg::CH_MINUS);
               st.acc      = 32'd0;
               st.phase    = asis_pkg::PH_SIGN;
            end else if (is_digit) begin
               st.negative = 1'b0;
               st.acc      = digit;
               st.phase    = asis_pkg::PH_DIGITS;
            end else begin
               st.reason = asis_pkg::RSN_BADCHAR;
               st.phase  = asis_pkg::PH_STOP;
            end
         end
      end

      // Line close: finish a pending number or flag a bare sign
      if (eol) begin
         if (st.phase == asis_pkg::PH_DIGITS && !emit) begin
            emit     = 1'b1;
            val      = st.negative ? (32'd0 - st.acc) : st.acc;
            st.count = st.count + 3'd1;
         end else if (st.phase == asis_pkg::PH_SIGN) begin
            st.reason = asis_pkg::RSN_NODIGIT;
         end
      end

      res.emit        = emit || eol;
      res.value       = val;
      res.value_valid = emit;
      res.line_end    = eol;
      res.field_count = st.count;
      res.stop_reason = eol ? st.reason : asis_pkg::RSN_NONE;

      nxt = eol ? asis_pkg::LINE_CLEAR : st;
   end

endmodule

// ===== src/ascii_signed_integer_scanner.sv =====
// Top level: input register, line state, result register of the integer scanner.
//
//  Channel  Dir  Fields
//  req_     in   tdata[7:0] = ch, tlast = end_of_line
//  rsp_     out  tdata[31:0] = value, [34:32] = field_count, [36:35] = stop_reason;
//                tuser = value_valid, tlast = line_end
//  csr_     in   wr_data[2:0] = max_fields
//
// One character per cycle sustained while rsp_ takes results; a req_ transfer is held in
// the input register, its result in the result register behind rsp_tvalid. The accumulate
// (acc*10 + digit, compare to limit) sits between the input register and the result
// register. Synchronous active-high reset clears the line state and sets max_fields to 7.
// A stalled rsp_ side holds one result; characters that make no result keep moving, the
// next one that makes a result waits in the input register and req_tready drops.
`timescale 1ns / 1ps

module ascii_signed_integer_scanner (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] value, [34:32] field_count, [36:35] stop_reason
   output logic        rsp_tuser,   // [0] value_valid
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_wr_data
);

   logic                     in_vld_ff;
   logic [7:0]               in_ch_ff;
   logic                     in_eol_ff;
   asis_pkg::line_state_type line_ff;
   asis_pkg::line_state_type line_in;
   logic [2:0]               max_fields_ff;
   asis_pkg::result_type     res;
   logic                     out_vld_ff;
   asis_pkg::result_type     out_ff;
   logic                     advance;

   // Step logic on the registered character
   asis_step u_step (
      .cur        (line_ff),
      .ch         (in_ch_ff),
      .eol        (in_eol_ff),
      .max_fields (max_fields_ff),
      .nxt        (line_in),
      .res        (res)
   );

   // Character moves on when its result (if any) has room
   assign advance    = in_vld_ff && (!res.emit || !out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_ch_ff  <= req_tdata;
         in_eol_ff <= req_tlast;
      end
   end

   // Line state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff       <= asis_pkg::LINE_CLEAR;
         max_fields_ff <= asis_pkg::MAX_FIELDS_RESET;
      end else begin
         if (advance) begin
            line_ff <= line_in;
         end
         if (csr_wr_en) begin
            max_fields_ff <= csr_wr_data;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance && res.emit) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res.emit) begin
         out_ff <= res;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {3'b000, out_ff.stop_reason, out_ff.field_count, out_ff.value};
   assign rsp_tuser  = out_ff.value_valid;
   assign rsp_tlast  = out_ff.line_end;

endmodule
